[hdl/shs_pkg.sv]
// Shared types, constants and bit functions of the SHA-256 stream hash.
package shs_pkg;

  typedef logic [31:0] word_t;
  typedef word_t hash_t [8];

  // Control from the sequencer to the schedule and round units.
  typedef struct packed {
    logic append;  // shift one byte into the block store
    logic init;    // load the working variables from the chaining words
    logic step;    // run one compression round
  } ctl_t;

  localparam hash_t HashInit = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t ror(input word_t x, input int unsigned s);
    return (x >> s) | (x << (32 - s));
  endfunction

  function automatic word_t big_sigma0(input word_t x);
    return ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    return ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    return ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    return ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
  endfunction

endpackage

[hdl/shs_sched.sv]
// Block store that doubles as the message schedule window.
module shs_sched import shs_pkg::*; (
  input  logic       clk_i,
  input  ctl_t       ctl_i,
  input  logic [7:0] byte_i,
  output word_t      w_o
);

  // Word j of the block sits at bits [511-32j -: 32]; bytes enter at the bottom.
  logic [511:0] buf_q, buf_d;
  word_t        w_new;

  assign w_o = buf_q[511:480];

  always_comb begin
    w_new = buf_q[511:480] + small_sigma0(buf_q[479:448]) + buf_q[223:192]
            + small_sigma1(buf_q[63:32]);
    buf_d = buf_q;
    if (ctl_i.append) begin
      buf_d = {buf_q[503:0], byte_i};
    end else if (ctl_i.step) begin
      buf_d = {buf_q[479:0], w_new};
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

endmodule

[hdl/shs_round.sv]
// Working variables and the shared compression round unit.
module shs_round import shs_pkg::*; (
  input  logic       clk_i,
  input  ctl_t       ctl_i,
  input  hash_t      chain_i,
  input  word_t      w_i,
  input  logic [5:0] rnd_i,
  output hash_t      v_o
);

  hash_t v_q;
  word_t t1, t2, choose, major;

  assign v_o = v_q;

  always_comb begin
    choose = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    major  = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    t1     = v_q[7] + big_sigma1(v_q[4]) + choose + RoundK[rnd_i] + w_i;
    t2     = big_sigma0(v_q[0]) + major;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.init) begin
      v_q <= chain_i;
    end else if (ctl_i.step) begin
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
  end

endmodule

[hdl/sha256_stream_hash.sv]
// Top level of the SHA-256 stream hash: sequencer, chaining words and digest output.
//
// Usage: the input channel carries one request per message byte. byte_present_i
// marks a real byte in data_byte_i, and message_end_i closes the message after
// that byte, so a request with only message_end_i set hashes an empty message.
// A plain byte that does not complete a 64-byte block is taken without a stall
// and in_ready_o stays high. The byte that completes a block starts a
// compression (64 rounds in one shared round unit, then the chaining add),
// during which in_ready_o is low.
// At message end the block pads itself one byte at a time: the 0x80 marker,
// zeros up to byte 56 of the block and the eight bytes of the bit length,
// each through the same byte path, with one or two compressions.
// The digest then leaves on the output channel as eight requests, word 0
// first, last_word_o set on word 7; a stalled receiver simply holds the
// current word and the block waits. After word 7 is taken the chaining words,
// fill count and length return to their initial values and in_ready_o rises.
// The wait from end request to first digest word is set by the byte-serial
// padding and the shared round unit.
// Reset (rst_ni low, asynchronous) loads the SHA-256 initial hash values and
// leaves the block idle and ready.
module sha256_stream_hash import shs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        byte_present_i,
  input  logic        message_end_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StPad80  = 3'd1;
  localparam logic [2:0] StPadZ   = 3'd2;
  localparam logic [2:0] StPadLen = 3'd3;
  localparam logic [2:0] StRound  = 3'd4;
  localparam logic [2:0] StFinal  = 3'd5;
  localparam logic [2:0] StOut    = 3'd6;

  logic [2:0]  state_q, state_d;
  logic [2:0]  ret_q, ret_d;     // where to go after a compression
  logic [5:0]  fill_q, fill_d;
  logic [5:0]  rnd_q, rnd_d;
  logic [2:0]  idx_q, idx_d;
  logic [63:0] total_q, total_d; // byte count, then bit length during padding
  hash_t       chain_q, chain_d;
  hash_t       v;
  word_t       w;
  ctl_t        ctl;
  logic [7:0]  app_byte;

  shs_sched u_sched (
    .clk_i  (clk_i),
    .ctl_i  (ctl),
    .byte_i (app_byte),
    .w_o    (w)
  );

  shs_round u_round (
    .clk_i   (clk_i),
    .ctl_i   (ctl),
    .chain_i (chain_q),
    .w_i     (w),
    .rnd_i   (rnd_q),
    .v_o     (v)
  );

  assign in_ready_o    = (state_q == StIdle);
  assign out_valid_o   = (state_q == StOut);
  assign digest_word_o = chain_q[idx_q];
  assign word_index_o  = idx_q;
  assign last_word_o   = (idx_q == 3'd7);

  always_comb begin
    state_d    = state_q;
    ret_d      = ret_q;
    fill_d     = fill_q;
    rnd_d      = rnd_q;
    idx_d      = idx_q;
    total_d    = total_q;
    chain_d    = chain_q;
    ctl        = '0;
    app_byte   = 8'h00;

    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          if (byte_present_i) begin
            ctl.append = 1'b1;
            app_byte   = data_byte_i;
            fill_d     = fill_q + 6'd1;
            total_d    = total_q + 64'd1;
          end
          if (byte_present_i && fill_q == 6'd63) begin
            // The block is full: compress, then pad if the message also ends.
            ctl.init = 1'b1;
            rnd_d    = 6'd0;
            state_d  = StRound;
            ret_d    = message_end_i ? StPad80 : StIdle;
          end else if (message_end_i) begin
            state_d = StPad80;
          end
        end
      end
      StPad80: begin
        ctl.append = 1'b1;
        app_byte   = 8'h80;
        fill_d     = fill_q + 6'd1;
        total_d    = {total_q[60:0], 3'b000};
        if (fill_q == 6'd63) begin
          ctl.init = 1'b1;
          rnd_d    = 6'd0;
          state_d  = StRound;
          ret_d    = StPadZ;
        end else begin
          state_d = StPadZ;
        end
      end
      StPadZ: begin
        if (fill_q == 6'd56) begin
          state_d = StPadLen;
        end else begin
          ctl.append = 1'b1;
          fill_d     = fill_q + 6'd1;
          if (fill_q == 6'd63) begin
            ctl.init = 1'b1;
            rnd_d    = 6'd0;
            state_d  = StRound;
            ret_d    = StPadZ;
          end
        end
      end
      StPadLen: begin
        ctl.append = 1'b1;
        app_byte   = total_q[63:56];
        total_d    = {total_q[55:0], 8'h00};
        fill_d     = fill_q + 6'd1;
        if (fill_q == 6'd63) begin
          ctl.init = 1'b1;
          rnd_d    = 6'd0;
          state_d  = StRound;
          ret_d    = StOut;
        end
      end
      StRound: begin
        ctl.step = 1'b1;
        rnd_d    = rnd_q + 6'd1;
        if (rnd_q == 6'd63) begin
          state_d = StFinal;
        end
      end
      StFinal: begin
        for (int j = 0; j < 8; j++) begin
          chain_d[j] = chain_q[j] + v[j];
        end
        idx_d   = 3'd0;
        state_d = ret_q;
      end
      StOut: begin
        if (out_ready_i) begin
          idx_d = idx_q + 3'd1;
          if (idx_q == 3'd7) begin
            chain_d = HashInit;
            total_d = 64'd0;
            fill_d  = 6'd0;
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ret_q   <= StIdle;
      fill_q  <= 6'd0;
      rnd_q   <= 6'd0;
      idx_q   <= 3'd0;
      total_q <= 64'd0;
      chain_q <= HashInit;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      fill_q  <= fill_d;
      rnd_q   <= rnd_d;
      idx_q   <= idx_d;
      total_q <= total_d;
      chain_q <= chain_d;
    end
  end

  // The input side is closed while a digest is being delivered.
  a_out_excludes_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input ready while digest is pending");

  // Taking the last digest word returns the block to idle.
  a_last_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && last_word_o) |=> in_ready_o)
    else $error("block not ready after last digest word");

  // The round loop always ends in the chaining add.
  a_round_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRound && rnd_q == 6'd63) |=> (state_q == StFinal))
    else $error("round loop did not reach the chaining add");

  // A byte that neither fills the block nor ends the message does not stall the input.
  a_plain_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && byte_present_i && !message_end_i
     && fill_q != 6'd63) |=> in_ready_o)
    else $error("plain byte stalled the input");

endmodule
